### rtl/tlfqs_pkg.sv
`timescale 1ns / 1ps

package tlfqs_pkg;

   localparam int DEF_QUEUE_DEPTH = 128;
   localparam int DEF_ID_BITS     = 8;

   localparam int NUM_LEVELS = 3;
   localparam int ALLOT_W    = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int USER_W     = 2;

   localparam logic [ALLOT_W-1:0] RELOAD_RESET = 16'd200;

   typedef logic [1:0] level_type;

   localparam level_type LVL_LOW  = 2'd0;
   localparam level_type LVL_MED  = 2'd1;
   localparam level_type LVL_HIGH = 2'd2;
   localparam level_type LVL_BAD  = 2'd3;

   typedef enum logic [1:0] {
      OP_ENQ      = 2'd0,
      OP_DEQ_HIGH = 2'd1,
      OP_DEQ_AT   = 2'd2,
      OP_BOOST    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_LEVEL = 2'd3
   } status_type;

   // request payload, last field in the lowest bits
   typedef struct packed {
      logic [5:0]         pad;
      logic [ALLOT_W-1:0] allotment_left;
      level_type          level;
      logic [7:0]         task_id;
   } req_data_type;

   // result payload, last field in the lowest bits
   typedef struct packed {
      logic [5:0]         pad;
      logic [7:0]         total_tasks;
      logic [ALLOT_W-1:0] out_allotment;
      level_type          out_level;
      logic [7:0]         out_task_id;
   } rsp_data_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic save_status;
      logic push;
      logic pop;
      logic take_pop;
      logic fresh_init;
      logic fresh_step;
      logic mv_next;
      logic mv_pop;
      logic mv_push;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   chk_ok;
      logic   fresh_done;
      logic   mv_empty;
      logic   mv_on_med;
      logic   rsp_free;
   } sts_type;

endpackage

### rtl/tlfqs_dp.sv
`timescale 1ns / 1ps

module tlfqs_dp #(
   parameter int QUEUE_DEPTH = tlfqs_pkg::DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = tlfqs_pkg::DEF_ID_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tlfqs_pkg::cmd_type                 cmd,
   output tlfqs_pkg::sts_type                 sts,
   input  logic [tlfqs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [tlfqs_pkg::USER_W-1:0]       req_tuser,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [tlfqs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [tlfqs_pkg::USER_W-1:0]       rsp_tuser,
   input  logic                               csr_wr_en,
   input  logic [tlfqs_pkg::ALLOT_W-1:0]      csr_wr_data
);
   import tlfqs_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
      return (a == LAST_IDX) ? '0 : a + AW'(1);
   endfunction

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h,
                                              input logic [CW-1:0] c);
      logic [CW:0] s;
      s = (CW+1)'(h) + (CW+1)'(c);
      if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
      return AW'(s);
   endfunction

   // request capture
   op_type             op_ff;
   logic [ID_BITS-1:0] id_ff;
   level_type          lvl_ff;
   logic [ALLOT_W-1:0] allot_ff;

   // result being built
   status_type         res_status_ff;
   logic [ID_BITS-1:0] res_id_ff;
   level_type          res_lvl_ff;
   logic [ALLOT_W-1:0] res_allot_ff;

   // queue bookkeeping
   logic [AW-1:0]      head_ff [NUM_LEVELS];
   logic [CW-1:0]      cnt_ff  [NUM_LEVELS];
   logic [ALLOT_W-1:0] reload_ff;

   // boost walk
   logic [AW-1:0]      sweep_ptr_ff;
   logic [CW-1:0]      sweep_left_ff;
   level_type          mv_lvl_ff;

   // memory ports
   logic [ID_BITS-1:0] rd_id_ff    [NUM_LEVELS];
   logic [ALLOT_W-1:0] rd_allot_ff [NUM_LEVELS];
   level_type          rd_lvl_ff;
   logic               rd_en;
   level_type          rd_lvl;
   logic [AW-1:0]      rd_addr;
   logic [CW-1:0]      rd_cnt;
   logic [ID_BITS-1:0] rd_id;
   logic [ALLOT_W-1:0] rd_allot;
   logic               wr_id_en;
   logic               wr_allot_en;
   level_type          wr_lvl;
   logic [AW-1:0]      wr_addr;
   logic [ID_BITS-1:0] wr_id;
   logic [ALLOT_W-1:0] wr_allot;
   logic               cnt_inc;

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   status_type            rsp_user_ff;

   logic [CW-1:0]      total_w;
   logic               full;
   level_type          src_lvl;
   level_type          enq_lvl;
   logic [ALLOT_W-1:0] enq_allot;
   status_type         chk_status;
   logic [CW-1:0]      lvl_cnt;
   logic [CW-1:0]      mv_cnt;
   logic [CW-1:0]      enq_cnt;
   logic [AW-1:0]      enq_head;
   req_data_type       req_d;

   function automatic logic [CW-1:0] cnt_of(input level_type l,
                                            input logic [CW-1:0] c0,
                                            input logic [CW-1:0] c1,
                                            input logic [CW-1:0] c2);
      logic [CW-1:0] r;
      case (l)
         LVL_LOW:  r = c0;
         LVL_MED:  r = c1;
         LVL_HIGH: r = c2;
         default:  r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [AW-1:0] head_of(input level_type l,
                                             input logic [AW-1:0] h0,
                                             input logic [AW-1:0] h1,
                                             input logic [AW-1:0] h2);
      logic [AW-1:0] r;
      case (l)
         LVL_LOW:  r = h0;
         LVL_MED:  r = h1;
         LVL_HIGH: r = h2;
         default:  r = '0;
      endcase
      return r;
   endfunction

   assign req_d   = req_data_type'(req_tdata);
   assign total_w = cnt_ff[0] + cnt_ff[1] + cnt_ff[2];
   assign full    = (total_w == DEPTH_C);
   assign lvl_cnt = cnt_of(lvl_ff, cnt_ff[0], cnt_ff[1], cnt_ff[2]);
   assign mv_cnt  = cnt_of(mv_lvl_ff, cnt_ff[0], cnt_ff[1], cnt_ff[2]);

   always_comb begin
      if (op_ff == OP_DEQ_HIGH) begin
         if (cnt_ff[2] != '0)      src_lvl = LVL_HIGH;
         else if (cnt_ff[1] != '0) src_lvl = LVL_MED;
         else                      src_lvl = LVL_LOW;
      end else begin
         src_lvl = lvl_ff;
      end
   end

   always_comb begin
      case (op_ff)
         OP_ENQ: begin
            if (lvl_ff == LVL_BAD) chk_status = ST_BAD_LEVEL;
            else if (full)         chk_status = ST_FULL;
            else                   chk_status = ST_OK;
         end
         OP_DEQ_HIGH: begin
            chk_status = (total_w == '0) ? ST_EMPTY : ST_OK;
         end
         OP_DEQ_AT: begin
            if (lvl_ff == LVL_BAD)   chk_status = ST_BAD_LEVEL;
            else if (lvl_cnt == '0)  chk_status = ST_EMPTY;
            else                     chk_status = ST_OK;
         end
         default: chk_status = ST_OK;
      endcase
   end

   // demote on an exhausted allotment; low level always starts fresh
   always_comb begin
      if (lvl_ff == LVL_LOW) begin
         enq_lvl   = LVL_LOW;
         enq_allot = reload_ff;
      end else if (allot_ff == '0) begin
         enq_lvl   = lvl_ff - 2'd1;
         enq_allot = reload_ff;
      end else begin
         enq_lvl   = lvl_ff;
         enq_allot = allot_ff;
      end
   end

   assign enq_cnt  = cnt_of(enq_lvl, cnt_ff[0], cnt_ff[1], cnt_ff[2]);
   assign enq_head = head_of(enq_lvl, head_ff[0], head_ff[1], head_ff[2]);

   assign rd_en   = cmd.pop | cmd.mv_pop;
   assign rd_lvl  = cmd.pop ? src_lvl : mv_lvl_ff;
   assign rd_addr = head_of(rd_lvl, head_ff[0], head_ff[1], head_ff[2]);
   assign rd_cnt  = cnt_of(rd_lvl, cnt_ff[0], cnt_ff[1], cnt_ff[2]);
   assign rd_id    = rd_id_ff[rd_lvl_ff];
   assign rd_allot = rd_allot_ff[rd_lvl_ff];

   always_comb begin
      wr_id_en    = 1'b0;
      wr_allot_en = 1'b0;
      wr_lvl      = LVL_HIGH;
      wr_addr     = wrap_add(head_ff[2], cnt_ff[2]);
      wr_id       = rd_id;
      wr_allot    = reload_ff;
      if (cmd.push) begin
         wr_id_en    = 1'b1;
         wr_allot_en = 1'b1;
         wr_lvl      = enq_lvl;
         wr_addr     = wrap_add(enq_head, enq_cnt);
         wr_id       = id_ff;
         wr_allot    = enq_allot;
      end else if (cmd.mv_push) begin
         wr_id_en    = 1'b1;
         wr_allot_en = 1'b1;
      end else if (cmd.fresh_step) begin
         wr_allot_en = 1'b1;
         wr_addr     = sweep_ptr_ff;
      end
   end

   assign cnt_inc = cmd.push | cmd.mv_push;

   for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_queue
      logic [ID_BITS-1:0] id_mem    [QUEUE_DEPTH];
      logic [ALLOT_W-1:0] allot_mem [QUEUE_DEPTH];

      always_ff @(posedge clock) begin
         if (wr_id_en && wr_lvl == 2'(g)) id_mem[wr_addr] <= wr_id;
         if (wr_allot_en && wr_lvl == 2'(g)) allot_mem[wr_addr] <= wr_allot;
         if (rd_en && rd_lvl == 2'(g)) begin
            rd_id_ff[g]    <= id_mem[rd_addr];
            rd_allot_ff[g] <= allot_mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         reload_ff    <= RELOAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) reload_ff <= csr_wr_data;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            if (rd_en && rd_lvl == 2'(i)) begin
               head_ff[i] <= wrap_inc(head_ff[i]);
               cnt_ff[i]  <= cnt_ff[i] - CW'(1);
            end else if (cnt_inc && wr_lvl == 2'(i)) begin
               cnt_ff[i]  <= cnt_ff[i] + CW'(1);
            end
         end
         if (cmd.load_rsp)    rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff         <= op_type'(req_tuser);
         id_ff         <= ID_BITS'(req_d.task_id);
         lvl_ff        <= req_d.level;
         allot_ff      <= req_d.allotment_left;
         res_status_ff <= ST_OK;
         res_id_ff     <= '0;
         res_lvl_ff    <= LVL_LOW;
         res_allot_ff  <= '0;
      end
      if (cmd.save_status) res_status_ff <= chk_status;
      if (cmd.take_pop) begin
         res_id_ff    <= rd_id;
         res_lvl_ff   <= rd_lvl_ff;
         res_allot_ff <= rd_allot;
      end
      if (rd_en) rd_lvl_ff <= rd_lvl;
      if (cmd.fresh_init) begin
         sweep_ptr_ff  <= head_ff[2];
         sweep_left_ff <= cnt_ff[2];
         mv_lvl_ff     <= LVL_LOW;
      end
      if (cmd.fresh_step) begin
         sweep_ptr_ff  <= wrap_inc(sweep_ptr_ff);
         sweep_left_ff <= sweep_left_ff - CW'(1);
      end
      if (cmd.mv_next) mv_lvl_ff <= LVL_MED;
      if (cmd.load_rsp) begin
         rsp_data_ff <= RSP_DATA_W'({8'(total_w), res_allot_ff, res_lvl_ff,
                                     8'(res_id_ff)});
         rsp_user_ff <= res_status_ff;
      end
   end

   assign sts.op         = op_ff;
   assign sts.chk_ok     = (chk_status == ST_OK);
   assign sts.fresh_done = (sweep_left_ff == '0);
   assign sts.mv_empty   = (mv_cnt == '0);
   assign sts.mv_on_med  = (mv_lvl_ff == LVL_MED);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = USER_W'(rsp_user_ff);

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_w <= DEPTH_C)
      else $error("task total exceeds queue depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> rd_cnt != '0)
      else $error("pop from an empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cnt_inc |-> !full)
      else $error("push into a full store");

   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_rsp))
      else $error("result valid rose without a load");
`endif

endmodule

### rtl/tlfqs_ctrl.sv
`timescale 1ns / 1ps

module tlfqs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  tlfqs_pkg::sts_type sts,
   output tlfqs_pkg::cmd_type cmd
);
   import tlfqs_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EXEC  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_FRESH = 7'b0001000,
      S_MV_RD = 7'b0010000,
      S_MV_WR = 7'b0100000,
      S_DONE  = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.save_status = 1'b1;
            case (sts.op)
               OP_ENQ: begin
                  cmd.push = sts.chk_ok;
                  state_in = S_DONE;
               end
               OP_DEQ_HIGH, OP_DEQ_AT: begin
                  cmd.pop  = sts.chk_ok;
                  state_in = sts.chk_ok ? S_READ : S_DONE;
               end
               OP_BOOST: begin
                  cmd.fresh_init = 1'b1;
                  state_in       = S_FRESH;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_READ: begin
            cmd.take_pop = 1'b1;
            state_in     = S_DONE;
         end
         S_FRESH: begin
            // rewrite the allotment of every high entry, then drain low and medium
            if (sts.fresh_done) state_in = S_MV_RD;
            else                cmd.fresh_step = 1'b1;
         end
         S_MV_RD: begin
            if (sts.mv_empty) begin
               if (sts.mv_on_med) state_in = S_DONE;
               else               cmd.mv_next = 1'b1;
            end else begin
               cmd.mv_pop = 1'b1;
               state_in   = S_MV_WR;
            end
         end
         S_MV_WR: begin
            cmd.mv_push = 1'b1;
            state_in    = S_MV_RD;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_EXEC)
      else $error("accepted request not executed next cycle");

   a_pop_then_take: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> cmd.take_pop)
      else $error("popped entry not taken");

   a_move_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.mv_pop |=> cmd.mv_push)
      else $error("moved entry not written to high queue");
`endif

endmodule

### rtl/three_level_feedback_queue_scheduler_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake          tuser (low bit up)  tdata (low bit up)
// req      in   req_tvalid/tready  opcode[1:0]         task_id[7:0], level[9:8],
//                                                      allotment_left[25:10], zero
// rsp      out  rsp_tvalid/tready  status[1:0]         out_task_id[7:0], out_level[9:8],
//                                                      out_allotment[25:10],
//                                                      total_tasks[33:26], zero
// csr      in   csr_wr_en          -                   csr_wr_data = allotment_reload
//
// Between accepts: enqueue executes and loads its result; dequeue adds one registered memory
// read when it pops, but not when it answers empty or invalid level;
// boost time grows with the H high, M medium and L low entries, set by the
// one-entry-per-cycle allotment rewrite and the read/write move through one port.
// Reset clears the head pointers, counts and result valid and loads the reload register
// with its default; the entry memories are not cleared, so no clearing pass is run.
// A finished result waits in the output register while the next request is taken;
// the controller holds in its final state while that register is still occupied.

module three_level_feedback_queue_scheduler_top #(
   parameter int QUEUE_DEPTH = tlfqs_pkg::DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = tlfqs_pkg::DEF_ID_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // task_id, level, allotment_left, zero fill
   input  logic [tlfqs_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [tlfqs_pkg::USER_W-1:0]     req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_task_id, out_level, out_allotment, total_tasks, zero fill
   output logic [tlfqs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [tlfqs_pkg::USER_W-1:0]     rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [tlfqs_pkg::ALLOT_W-1:0]    csr_wr_data
);
   import tlfqs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence each transfer: execute, walk boost, load the result
   tlfqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // queues, pointers, counts, reload register and output register
   tlfqs_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

### tb/three_level_feedback_queue_scheduler_top_tb.sv
`timescale 1ns / 1ps

module three_level_feedback_queue_scheduler_top_tb;

   import tlfqs_pkg::*;

   localparam int          CLK_PERIOD    = 10;
   localparam int          RESET_CYCLES  = 9;
   localparam int          DEPTH         = DEF_QUEUE_DEPTH;
   localparam int          RANDOM_PHASES = 10;
   localparam int          PHASE_ITEMS   = 113;
   localparam int          LONG_HOLD     = 300;
   localparam int          TAIL_CYCLES   = 32;
   localparam int          MAX_REPORTS   = 10;
   // worst case: ~1200 boosts on a full store, taken three times over
   localparam int unsigned RUN_LIMIT     = 1_000_000;

   typedef struct packed {
      logic [7:0]         id;
      logic [ALLOT_W-1:0] allot;
   } task_slot_t;

   typedef struct packed {
      logic [1:0]   status;
      rsp_data_type data;
   } sched_reply_t;

   typedef enum {MIX_FILL, MIX_BALANCED, MIX_TOP_UP, MIX_DRAIN} mix_kind_t;

   // Mirror of the three priority queues plus the replies still owed by the block.
   class sched_scoreboard;
      int unsigned  depth;
      logic [15:0]  reload;
      task_slot_t   held_q [NUM_LEVELS][$];
      sched_reply_t pending_q [$];
      int unsigned  accepted, results_seen, mismatches, peak_total;
      int unsigned  op_hits [4];
      int unsigned  status_hits [4];

      function new(int unsigned queue_depth);
         depth  = queue_depth;
         reload = RELOAD_RESET;
      endfunction

      function int unsigned held_total();
         return held_q[0].size() + held_q[1].size() + held_q[2].size();
      endfunction

      function int unsigned outstanding();
         return pending_q.size();
      endfunction

      // Apply one accepted request to the queues and log the reply it must produce.
      function void note_request(op_type op, logic [7:0] id, level_type lvl,
                                 logic [15:0] allot);
         sched_reply_t want;
         task_slot_t   slot;
         level_type    src, dest;
         int           lv, i;
         bit           found;
         want        = '0;
         want.status = ST_OK;
         slot        = '0;
         src         = LVL_LOW;
         found       = 1'b0;
         case (op)
            OP_ENQ: begin
               if (lvl == LVL_BAD) begin
                  want.status = ST_BAD_LEVEL;
               end else if (held_total() >= depth) begin
                  want.status = ST_FULL;
               end else begin
                  // spent tasks drop one level; low tasks and spent tasks get a fresh allotment
                  dest       = (lvl != LVL_LOW && allot == '0) ? level_type'(lvl - 2'd1) : lvl;
                  slot.id    = id;
                  slot.allot = (lvl == LVL_LOW || allot == '0) ? reload : allot;
                  held_q[dest].push_back(slot);
               end
            end
            OP_DEQ_HIGH, OP_DEQ_AT: begin
               if (op == OP_DEQ_AT) begin
                  if (lvl == LVL_BAD) begin
                     want.status = ST_BAD_LEVEL;
                  end else if (held_q[lvl].size() == 0) begin
                     want.status = ST_EMPTY;
                  end else begin
                     src   = lvl;
                     found = 1'b1;
                  end
               end else begin
                  for (lv = 2; lv >= 0; lv--) begin
                     if (!found && held_q[lv].size() != 0) begin
                        src   = level_type'(lv);
                        found = 1'b1;
                     end
                  end
                  if (!found) want.status = ST_EMPTY;
               end
               if (found) begin
                  slot                    = held_q[src].pop_front();
                  want.data.out_task_id   = slot.id;
                  want.data.out_level     = src;
                  want.data.out_allotment = slot.allot;
               end
            end
            default: begin
               // low entries first, then medium, onto the tail of high
               for (lv = 0; lv < 2; lv++) begin
                  while (held_q[lv].size() != 0) held_q[LVL_HIGH].push_back(held_q[lv].pop_front());
               end
               for (i = 0; i < held_q[LVL_HIGH].size(); i++) begin
                  slot                 = held_q[LVL_HIGH][i];
                  slot.allot           = reload;
                  held_q[LVL_HIGH][i]  = slot;
               end
            end
         endcase
         want.data.total_tasks = 8'(held_total());
         if (held_total() > peak_total) peak_total = held_total();
         op_hits[op]++;
         status_hits[want.status]++;
         accepted++;
         pending_q.push_back(want);
      endfunction

      function void log_mismatch(string field, logic [41:0] want, logic [41:0] seen);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                     $time, results_seen, field, want, seen);
      endfunction

      // Compare one reply transfer against the oldest owed reply.
      function void check_reply(logic [1:0] got_status, rsp_data_type got);
         sched_reply_t want;
         results_seen++;
         if (pending_q.size() == 0) begin
            log_mismatch("result with nothing outstanding", '0, {got_status, got});
            return;
         end
         want = pending_q.pop_front();
         if (got_status !== want.status) log_mismatch("status", want.status, got_status);
         if (got.out_task_id !== want.data.out_task_id)
            log_mismatch("out_task_id", want.data.out_task_id, got.out_task_id);
         if (got.out_level !== want.data.out_level)
            log_mismatch("out_level", want.data.out_level, got.out_level);
         if (got.out_allotment !== want.data.out_allotment)
            log_mismatch("out_allotment", want.data.out_allotment, got.out_allotment);
         if (got.total_tasks !== want.data.total_tasks)
            log_mismatch("total_tasks", want.data.total_tasks, got.total_tasks);
         if (got.pad !== want.data.pad) log_mismatch("zero fill", want.data.pad, got.pad);
      endfunction
   endclass

   // Every block input starts at a known value; reset is held from time zero.
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [USER_W-1:0]     req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [USER_W-1:0]     rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic [ALLOT_W-1:0]    csr_wr_data = '0;

   sched_scoreboard board;
   bit              no_idle      = 1'b0;  // both sides skip their random gaps while set
   bit              rsp_hold_req = 1'b0;  // ask the reply side for one long hold-off
   int unsigned     cycle_count  = 0;
   int unsigned     reload_writes = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   three_level_feedback_queue_scheduler_top #(
      .QUEUE_DEPTH (DEPTH),
      .ID_BITS     (DEF_ID_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Offer one request after a random gap and hold it until the transfer happens.
   // Keep tvalid high across back-to-back requests: only one assignment per edge.
   task automatic send_request(op_type op, logic [7:0] id, level_type lvl,
                               logic [15:0] allot);
      req_data_type payload;
      int           gap;
      payload                = '0;
      payload.task_id        = id;
      payload.level          = lvl;
      payload.allotment_left = allot;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= payload;
      req_tuser  <= op;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_request(op, id, lvl, allot);
   endtask

   // Stop offering and hold until every owed reply has come back.
   task automatic wait_for_replies();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   // Write the reload register; only called with the block idle.
   task automatic write_reload(logic [15:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      board.reload = value;
      reload_writes++;
   endtask

   // Reply side: draw a stall per reply, take a long hold-off on request, then accept
   // and check the reply transfer at the rising edge.
   initial begin : reply_sink
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 7);
         @(negedge clock);
         if (rsp_hold_req) begin
            // let the block back up into its request port
            stall        = LONG_HOLD;
            rsp_hold_req = 1'b0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         board.check_reply(rsp_tuser, rsp_tdata);
      end
   end

   // Watchdog: drop the run if it stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies still owed",
                  cycle_count, board.outstanding());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : request_source
      op_type      op;
      level_type   lvl;
      logic [7:0]  id;
      logic [15:0] allot, reload;
      mix_kind_t   kind;
      int          phase, roll, enq_pct, deq_pct, at_pct;
      board = new(DEPTH);
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed part, reload at its reset value. Start with everything empty:
      // both dequeues answer empty, bad level beats everything, boost on nothing.
      send_request(OP_DEQ_HIGH, 8'hFF, LVL_BAD, 16'hFFFF);
      send_request(OP_DEQ_AT, 8'h00, LVL_LOW, 16'h0000);
      send_request(OP_DEQ_AT, 8'h5A, LVL_BAD, 16'h1234);
      send_request(OP_ENQ, 8'h11, LVL_BAD, 16'h0005);
      send_request(OP_BOOST, 8'hA5, LVL_MED, 16'hA5A5);
      // Enqueue at each level: kept, demoted when spent, fresh allotment at low.
      send_request(OP_ENQ, 8'hFF, LVL_HIGH, 16'hFFFF);
      send_request(OP_ENQ, 8'h00, LVL_HIGH, 16'h0000);
      send_request(OP_ENQ, 8'hA5, LVL_MED, 16'h0001);
      send_request(OP_ENQ, 8'h5A, LVL_MED, 16'h0000);
      send_request(OP_ENQ, 8'h3C, LVL_LOW, 16'hFFFF);
      send_request(OP_ENQ, 8'hC3, LVL_LOW, 16'h0000);
      send_request(OP_ENQ, 8'h96, LVL_HIGH, 16'h5A5A);
      send_request(OP_DEQ_AT, 8'h77, LVL_MED, 16'hFFFF);
      send_request(OP_DEQ_HIGH, 8'h88, LVL_LOW, 16'h0000);
      // Boost with all three queues holding tasks, then check the lower ones are empty.
      send_request(OP_BOOST, 8'h00, LVL_BAD, 16'hFFFF);
      send_request(OP_DEQ_AT, 8'hFF, LVL_LOW, 16'hFFFF);
      send_request(OP_DEQ_AT, 8'hFF, LVL_MED, 16'h0000);
      send_request(OP_DEQ_AT, 8'h00, LVL_HIGH, 16'hFFFF);
      send_request(OP_DEQ_HIGH, 8'hFF, LVL_HIGH, 16'hFFFF);
      // Zero reload is stored and handed out as is.
      wait_for_replies();
      write_reload(16'd0);
      send_request(OP_ENQ, 8'h7E, LVL_LOW, 16'hA5A5);
      send_request(OP_ENQ, 8'h81, LVL_HIGH, 16'h0000);
      send_request(OP_BOOST, 8'h42, LVL_LOW, 16'h5A5A);
      send_request(OP_DEQ_HIGH, 8'h24, LVL_BAD, 16'h0000);

      // Random part: phases that fill, balance, top up to a full store, or drain,
      // each under a new reload value. State carries over from phase to phase.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_replies();
         case (phase)
            0:       reload = 16'd1;
            1:       reload = 16'hFFFF;
            2:       reload = 16'd0;
            3:       reload = RELOAD_RESET;
            7:       reload = 16'hFFFF;
            8:       reload = 16'd1;
            default: reload = 16'($urandom_range(1, 16'hFFFE));
         endcase
         write_reload(reload);
         case (phase % 4)
            0:       kind = MIX_FILL;
            1:       kind = MIX_BALANCED;
            2:       kind = MIX_TOP_UP;
            default: kind = MIX_DRAIN;
         endcase
         no_idle = (phase == 4 || phase == 7);
         if (phase == 2) rsp_hold_req = 1'b1;
         case (kind)
            MIX_FILL:     begin enq_pct = 80; deq_pct = 88; at_pct = 95; end
            MIX_BALANCED: begin enq_pct = 45; deq_pct = 70; at_pct = 92; end
            MIX_TOP_UP:   begin enq_pct = 60; deq_pct = 75; at_pct = 90; end
            default:      begin enq_pct = 15; deq_pct = 60; at_pct = 95; end
         endcase
         repeat (PHASE_ITEMS) begin
            roll  = $urandom_range(0, 99);
            id    = 8'($urandom);
            allot = 16'($urandom);
            if ($urandom_range(0, 5) == 0) allot = 16'h0000;
            else if ($urandom_range(0, 9) == 0) allot = 16'hFFFF;
            lvl = ($urandom_range(0, 15) == 0) ? LVL_BAD : level_type'($urandom_range(0, 2));
            if (kind == MIX_TOP_UP && board.held_total() < DEPTH) begin
               // push straight to a full store, then hover there
               op = OP_ENQ;
               if (lvl == LVL_BAD) lvl = LVL_HIGH;
            end else if (roll < enq_pct) begin
               op = OP_ENQ;
            end else if (roll < deq_pct) begin
               op = OP_DEQ_HIGH;
            end else if (roll < at_pct) begin
               op = OP_DEQ_AT;
            end else begin
               op = OP_BOOST;
            end
            send_request(op, id, lvl, allot);
         end
      end
      no_idle = 1'b0;

      // Drain, then give the block time to show any stray reply.
      wait_for_replies();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests: enqueue %0d, dequeue highest %0d, dequeue at level %0d,",
               board.accepted, board.op_hits[OP_ENQ], board.op_hits[OP_DEQ_HIGH],
               board.op_hits[OP_DEQ_AT]);
      $display("boost %0d; ok %0d, empty %0d, full %0d, bad level %0d; peak %0d of %0d, %0d reloads",
               board.op_hits[OP_BOOST], board.status_hits[ST_OK], board.status_hits[ST_EMPTY],
               board.status_hits[ST_FULL], board.status_hits[ST_BAD_LEVEL], board.peak_total,
               DEPTH, reload_writes);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d replies still owed", board.mismatches,
                  board.outstanding());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
